// ===== hw/rtl/kmsce_pkg.sv =====
// Shared types and constants for the key matrix change-event scanner.
package kmsce_pkg;

    localparam int SENSE_W = 5;   // row sense bits per scan tick
    localparam int ROW_W   = 3;   // key_row field width
    localparam int COL_W   = 4;   // key_col / drive_col field width
    localparam int ADDR_W  = 5;   // state memory address, wide enough for 32 columns

    typedef struct packed {
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [SENSE_W-1:0] wr_data;
    } t_mem_req;

    typedef struct packed {
        logic             event_valid;
        logic [ROW_W-1:0] key_row;
        logic [COL_W-1:0] key_col;
        logic             pressed;
        logic [COL_W-1:0] drive_col;
        logic             last;
    } t_evt_word;

endpackage

// ===== hw/rtl/kmsce_in_if.sv =====
// Scan tick channel: row sense word with valid/ready.
interface kmsce_in_if;
    logic                          valid;
    logic                          ready;
    logic [kmsce_pkg::SENSE_W-1:0] row_sense;

    modport source (output valid, output row_sense, input ready);
    modport sink   (input valid, input row_sense, output ready);
endinterface

// ===== hw/rtl/kmsce_out_if.sv =====
// Key event channel: one result word per handshake.
interface kmsce_out_if;
    logic                        valid;
    logic                        ready;
    logic                        event_valid;
    logic [kmsce_pkg::ROW_W-1:0] key_row;
    logic [kmsce_pkg::COL_W-1:0] key_col;
    logic                        pressed;
    logic [kmsce_pkg::COL_W-1:0] drive_col;
    logic                        last;

    modport source (output valid, output event_valid, output key_row, output key_col,
                    output pressed, output drive_col, output last, input ready);
    modport sink   (input valid, input event_valid, input key_row, input key_col,
                    input pressed, input drive_col, input last, output ready);
endinterface

// ===== hw/rtl/kmsce_state_mem.sv =====
// Per-column key state memory: one read and one write port, registered read, valid bits.
module kmsce_state_mem #(
    parameter int COLUMNS = 16,
    parameter int CW      = 4
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  kmsce_pkg::t_mem_req           i_req,
    output logic [kmsce_pkg::SENSE_W-1:0] o_rd_data
);

    logic [kmsce_pkg::SENSE_W-1:0] r_mem [COLUMNS];
    logic [COLUMNS-1:0]            r_valid;
    logic [kmsce_pkg::SENSE_W-1:0] r_rd_data;
    logic                          r_rd_ok;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr[CW-1:0]] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.rd_addr[CW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_rd_ok <= 1'b0;
        end else begin
            if (i_req.wr_en) begin
                r_valid[i_req.wr_addr[CW-1:0]] <= 1'b1;
            end
            if (i_req.rd_en) begin
                r_rd_ok <= r_valid[i_req.rd_addr[CW-1:0]];
            end
        end
    end

    // never-written column reads as no keys pressed
    assign o_rd_data = r_rd_ok ? r_rd_data : '0;

    a_valid_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_valid == '0) && !r_rd_ok)
        else $error("valid bits not cleared by reset");

    a_valid_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.wr_en |=> r_valid[$past(i_req.wr_addr[CW-1:0])])
        else $error("written entry not marked valid");

    a_no_rw_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_req.rd_en && i_req.wr_en))
        else $error("read and write of state memory in the same cycle");

endmodule

// ===== hw/rtl/kmsce_ctrl.sv =====
// Scan sequencer: read-modify-write of column state and serial event emission.
module kmsce_ctrl #(
    parameter int COLUMNS = 16,
    parameter int ROWS    = 5,
    parameter int CW      = 4
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [kmsce_pkg::SENSE_W-1:0] i_row_sense,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output kmsce_pkg::t_evt_word          o_out_word,
    output kmsce_pkg::t_mem_req           o_mem_req,
    input  logic [kmsce_pkg::SENSE_W-1:0] i_mem_rd_data
);

    localparam logic [kmsce_pkg::SENSE_W-1:0] LIVE_ROWS =
        (ROWS >= kmsce_pkg::SENSE_W) ? '1 : kmsce_pkg::SENSE_W'((1 << ROWS) - 1);
    localparam logic [CW-1:0] COL_LAST = CW'(COLUMNS - 1);

    typedef enum logic [1:0] {S_IDLE, S_READ, S_EMIT} t_state;

    t_state                        r_state;
    logic [CW-1:0]                 r_col;
    logic [CW-1:0]                 r_ev_col;
    logic [kmsce_pkg::SENSE_W-1:0] r_now;
    logic [kmsce_pkg::SENSE_W-1:0] r_changes;
    logic                          r_out_valid;
    kmsce_pkg::t_evt_word          r_out_word;

    logic                          in_fire;
    logic                          slot_free;
    logic [kmsce_pkg::SENSE_W-1:0] low_bit;
    logic [kmsce_pkg::ROW_W-1:0]   low_idx;
    logic [kmsce_pkg::SENSE_W-1:0] remain;
    logic [CW-1:0]                 col_adv;

    assign in_fire   = i_in_valid && o_in_ready;
    assign slot_free = !r_out_valid || i_out_ready;
    assign col_adv   = (r_col == COL_LAST) ? '0 : r_col + CW'(1);

    // lowest changed row
    always_comb begin
        low_idx = '0;
        for (int i = kmsce_pkg::SENSE_W - 1; i >= 0; i--) begin
            if (r_changes[i]) begin
                low_idx = kmsce_pkg::ROW_W'(i);
            end
        end
        low_bit = r_changes & (~r_changes + kmsce_pkg::SENSE_W'(1));
        remain  = r_changes & ~low_bit;
    end

    always_comb begin
        o_mem_req         = '0;
        o_mem_req.rd_en   = in_fire;
        o_mem_req.rd_addr = kmsce_pkg::ADDR_W'(r_col);
        o_mem_req.wr_en   = (r_state == S_READ);
        o_mem_req.wr_addr = kmsce_pkg::ADDR_W'(r_col);
        o_mem_req.wr_data = r_now;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_col       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        r_now   <= ~i_row_sense & LIVE_ROWS;
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    // stored flags arrive now; write back and step the column
                    r_changes <= r_now ^ i_mem_rd_data;
                    r_ev_col  <= r_col;
                    r_col     <= col_adv;
                    r_state   <= S_EMIT;
                end
                S_EMIT: begin
                    if (slot_free) begin
                        r_out_valid          <= 1'b1;
                        r_out_word.drive_col <= kmsce_pkg::COL_W'(r_col);
                        if (r_changes == '0) begin
                            r_out_word.event_valid <= 1'b0;
                            r_out_word.key_row     <= '0;
                            r_out_word.key_col     <= '0;
                            r_out_word.pressed     <= 1'b0;
                            r_out_word.last        <= 1'b1;
                            r_state                <= S_IDLE;
                        end else begin
                            r_out_word.event_valid <= 1'b1;
                            r_out_word.key_row     <= low_idx;
                            r_out_word.key_col     <= kmsce_pkg::COL_W'(r_ev_col);
                            r_out_word.pressed     <= |(r_now & low_bit);
                            r_out_word.last        <= (remain == '0);
                            r_changes              <= remain;
                            if (remain == '0) begin
                                r_state <= S_IDLE;
                            end
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_col <= COL_LAST)
        else $error("column counter out of range");

    a_col_moves_on_wb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_mem_req.wr_en |=> $stable(r_col))
        else $error("column advanced without state write-back");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> !o_in_ready ##1 !o_in_ready)
        else $error("new tick taken during read-modify-write");

    a_last_ends_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) && slot_free && ((r_changes == '0) || (remain == '0))
            |=> o_in_ready && r_out_word.last)
        else $error("final word did not return sequencer to idle");

endmodule

// ===== hw/rtl/key_matrix_scan_change_events.sv =====
// Key matrix scanner: per-column change events from scan ticks.
// First result word: loaded into the output register in state S_EMIT, after S_READ, once the
//   output register is free. Per tick: one state memory read-modify-write, then N result
//   words, N = results of that tick (1 to 5), one per cycle while o_evt.ready takes them;
//   no new tick is accepted until the tick's last word is loaded into the output register.
// Reset (synchronous, active low): column counter to 0, all column valid bits cleared so
//   every column reads as no keys pressed; no clearing pass, ticks accepted right away.
module key_matrix_scan_change_events #(
    parameter int COLUMNS = 16,
    parameter int ROWS    = 5
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    kmsce_in_if.sink           i_tick,
    kmsce_out_if.source        o_evt
);

    localparam int CW = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;

    kmsce_pkg::t_mem_req           mem_req;
    logic [kmsce_pkg::SENSE_W-1:0] mem_rd_data;
    kmsce_pkg::t_evt_word          out_word;

    kmsce_state_mem #(
        .COLUMNS (COLUMNS),
        .CW      (CW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (mem_req),
        .o_rd_data (mem_rd_data)
    );

    kmsce_ctrl #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS),
        .CW      (CW)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_tick.valid),
        .o_in_ready    (i_tick.ready),
        .i_row_sense   (i_tick.row_sense),
        .o_out_valid   (o_evt.valid),
        .i_out_ready   (o_evt.ready),
        .o_out_word    (out_word),
        .o_mem_req     (mem_req),
        .i_mem_rd_data (mem_rd_data)
    );

    assign o_evt.event_valid = out_word.event_valid;
    assign o_evt.key_row     = out_word.key_row;
    assign o_evt.key_col     = out_word.key_col;
    assign o_evt.pressed     = out_word.pressed;
    assign o_evt.drive_col   = out_word.drive_col;
    assign o_evt.last        = out_word.last;

endmodule
